>>> hdl/rt11_directory_entry_decoder_defines.svh
// assertion macros for the rt11 directory entry decoder
`ifndef RT11_DIRECTORY_ENTRY_DECODER_DEFINES_SVH
`define RT11_DIRECTORY_ENTRY_DECODER_DEFINES_SVH

// condition must hold in the same cycle
`define RT11DE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rt11de: same-cycle check failed");

// condition must hold in the next cycle
`define RT11DE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rt11de: next-cycle check failed");

`endif

>>> hdl/rt11de_pkg.sv
// shared types, constants and decode functions of the rt11 directory entry decoder
package rt11de_pkg;

    localparam int unsigned ENTRY_COUNT_DEF = 72;
    localparam int unsigned HDR_BYTES       = 10;
    localparam int unsigned ENT_BYTES       = 14;
    localparam int unsigned Q_DEPTH         = 2;
    localparam int unsigned Q_LVL_W         = $clog2(Q_DEPTH + 1);
    localparam logic [6:0]  YEAR_BIAS       = 7'd72;
    localparam logic [7:0]  BAD_CHAR        = 8'h3F;
    localparam logic [5:0]  RAD_BASE        = 6'd40;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       segment_start;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  status_low;
        logic [7:0]  entry_kind;
        logic [47:0] stem_ascii;
        logic [23:0] ext_ascii;
        logic        name_invalid;
        logic [15:0] start_block;
        logic [15:0] length_blocks;
        logic [7:0]  job_number;
        logic [7:0]  channel_number;
        logic [4:0]  day_of_month;
        logic [3:0]  month_number;
        logic [6:0]  year_since_1900;
    } t_out_word;

    // one complete raw entry plus its start block
    typedef struct packed {
        logic [ENT_BYTES-1:0][7:0] raw;
        logic [15:0]               start_block;
    } t_job;

    typedef struct packed {
        logic               empty;
        logic               full;
        logic [Q_LVL_W-1:0] level;
    } t_q_status;

    // w / 40 by reciprocal, exact over 16 bits
    function automatic logic [10:0] f_div40(input logic [15:0] w);
        logic [32:0] p;
        p = {17'd0, w} * 33'd52429;
        return p[31:21];
    endfunction

    // w / 1600 by reciprocal, exact over 16 bits
    function automatic logic [5:0] f_div1600(input logic [15:0] w);
        logic [32:0] p;
        p = {17'd0, w} * 33'd83887;
        return p[32:27];
    endfunction

    // rad50 digit to ascii, out of range gives the bad character
    function automatic logic [7:0] f_rad_char(input logic [5:0] d);
        logic [7:0] c;
        if (d == 6'd0) begin
            c = 8'h20;
        end else if (d <= 6'd26) begin
            c = {2'b00, d} + 8'h40;
        end else if (d == 6'd27) begin
            c = 8'h24;
        end else if (d == 6'd28) begin
            c = 8'h2E;
        end else if (d == 6'd29) begin
            c = 8'h25;
        end else if (d < RAD_BASE) begin
            c = {2'b00, d} + 8'h12;
        end else begin
            c = BAD_CHAR;
        end
        return c;
    endfunction

endpackage

>>> hdl/rt11_directory_entry_decoder.sv
// top level of the rt11 directory segment entry decoder
//
// input channel: one segment byte per word (data_byte, segment_start) under
// valid/ready. segment_start marks header byte 0 and restarts the parse.
// after the 10-byte header, every 14th byte closes an entry and yields one
// output word with the decoded name, blocks, job/channel and date.
// bytes after the last entry are taken and dropped until the next start.
// an entry passes queue write, quotient stage and output register in that
// order after the edge that takes its last byte. throughput: one byte per
// cycle while the queue is not full; the decoder pipeline drains one entry
// per cycle unless the output stalls, far above one entry per 14 input bytes.
// the parser feeds a 2-deep entry queue; when the receiver stalls the output
// register holds its word, the decoder pipeline fills, then the queue, and
// only a full queue drops input ready.
// reset (synchronous, active low) empties queue and pipeline and leaves the
// parser waiting for a start word.
module rt11_directory_entry_decoder
    import rt11de_pkg::*;
#(
    parameter int unsigned ENTRY_COUNT = ENTRY_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

`include "rt11_directory_entry_decoder_defines.svh"

    t_q_status w_q_status;
    logic      w_q_push;
    logic      w_q_pop;
    t_job      w_push_job;
    t_job      w_pop_job;

    rt11de_front #(
        .ENTRY_COUNT(ENTRY_COUNT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .i_q_status (w_q_status),
        .o_q_push   (w_q_push),
        .o_q_job    (w_push_job)
    );

    rt11de_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_q_push),
        .i_job    (w_push_job),
        .i_pop    (w_q_pop),
        .o_job    (w_pop_job),
        .o_status (w_q_status)
    );

    rt11de_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_job     (w_pop_job),
        .i_q_status  (w_q_status),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // year field always lands in the biased range
    `RT11DE_ASSERT_NOW(a_year_range, o_out_valid, (o_out_word.year_since_1900 >= 7'd72) && (o_out_word.year_since_1900 <= 7'd103))

    // a clean name never carries the bad character in a leading position
    `RT11DE_ASSERT_NOW(a_name_flag, o_out_valid && !o_out_word.name_invalid, (o_out_word.stem_ascii[47:40] != BAD_CHAR) && (o_out_word.stem_ascii[23:16] != BAD_CHAR) && (o_out_word.ext_ascii[23:16] != BAD_CHAR))

    // queue never overfills
    `RT11DE_ASSERT_NOW(a_level_bound, 1'b1, w_q_status.level <= Q_LVL_W'(Q_DEPTH))

    // a push into an empty queue is visible on the next cycle
    `RT11DE_ASSERT_NEXT(a_push_seen, w_q_push && w_q_status.empty, !w_q_status.empty)

endmodule

>>> hdl/rt11de_fifo.sv
// short queue of raw entries between the byte parser and the decoder
module rt11de_fifo
    import rt11de_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_job      i_job,
    input  logic      i_pop,
    output t_job      o_job,
    output t_q_status o_status
);

    localparam int unsigned PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    t_job               r_mem [Q_DEPTH];
    logic [PTR_W-1:0]   r_wptr;
    logic [PTR_W-1:0]   r_rptr;
    logic [Q_LVL_W-1:0] r_level;
    logic [PTR_W-1:0]   n_wptr;
    logic [PTR_W-1:0]   n_rptr;
    logic [Q_LVL_W-1:0] n_level;
    logic               do_push;
    logic               do_pop;

    assign o_status.empty = (r_level == '0);
    assign o_status.full  = (r_level == Q_LVL_W'(Q_DEPTH));
    assign o_status.level = r_level;
    assign o_job          = r_mem[r_rptr];

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_level = r_level;
        if (do_push) begin
            n_wptr = (r_wptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_level = r_level + Q_LVL_W'(1);
        end else if (do_pop && !do_push) begin
            n_level = r_level - Q_LVL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

>>> hdl/rt11de_front.sv
// byte parser: tracks header and entry position, collects entries, tracks start block
module rt11de_front
    import rt11de_pkg::*;
#(
    parameter int unsigned ENTRY_COUNT = ENTRY_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    input  t_q_status i_q_status,
    output logic      o_q_push,
    output t_job      o_q_job
);

    localparam int unsigned ENT_W  = $clog2(ENTRY_COUNT + 1);
    localparam int unsigned HPOS_W = $clog2(HDR_BYTES);
    localparam int unsigned OFF_W  = $clog2(ENT_BYTES);

    logic              r_done;
    logic              r_in_hdr;
    logic [HPOS_W-1:0] r_hpos;
    logic [OFF_W-1:0]  r_off;
    logic [ENT_W-1:0]  r_ent;
    logic [15:0]       r_running;
    logic [7:0]        r_hdr_low;
    logic [7:0]        r_ent_bytes [ENT_BYTES-1];

    logic              n_done;
    logic              n_in_hdr;
    logic [HPOS_W-1:0] n_hpos;
    logic [OFF_W-1:0]  n_off;
    logic [ENT_W-1:0]  n_ent;
    logic [15:0]       n_running;
    logic [7:0]        n_hdr_low;

    logic              accept;
    logic              start;
    logic              active;
    logic              eff_hdr;
    logic [HPOS_W-1:0] eff_hpos;
    logic              last_off;
    logic              store_byte;
    logic [15:0]       len;
    logic [7:0]        b;

    assign o_in_ready = !i_q_status.full;
    assign accept     = i_in_valid && o_in_ready;
    assign b          = i_in_word.data_byte;
    assign start      = i_in_word.segment_start;
    // a start word always counts as header byte zero
    assign active     = accept && (start || !r_done);
    assign eff_hdr    = start || r_in_hdr;
    assign eff_hpos   = start ? '0 : r_hpos;
    assign last_off   = (r_off == OFF_W'(ENT_BYTES - 1));
    assign store_byte = active && !eff_hdr && !last_off;
    assign o_q_push   = active && !eff_hdr && last_off;
    assign len        = {r_ent_bytes[9], r_ent_bytes[8]};

    always_comb begin
        for (int i = 0; i < ENT_BYTES - 1; i++) begin
            o_q_job.raw[i] = r_ent_bytes[i];
        end
        o_q_job.raw[ENT_BYTES-1] = b;
        o_q_job.start_block      = r_running;
    end

    always_comb begin
        n_done    = r_done;
        n_in_hdr  = r_in_hdr;
        n_hpos    = r_hpos;
        n_off     = r_off;
        n_ent     = r_ent;
        n_running = r_running;
        n_hdr_low = r_hdr_low;
        if (active) begin
            n_done = 1'b0;
            if (eff_hdr) begin
                n_off = '0;
                n_ent = '0;
                if (eff_hpos == HPOS_W'(HDR_BYTES - 2)) begin
                    n_hdr_low = b;
                end
                if (eff_hpos == HPOS_W'(HDR_BYTES - 1)) begin
                    n_running = {b, r_hdr_low};
                    n_in_hdr  = 1'b0;
                    n_hpos    = '0;
                end else begin
                    n_in_hdr = 1'b1;
                    n_hpos   = eff_hpos + HPOS_W'(1);
                end
            end else if (!last_off) begin
                n_off = r_off + OFF_W'(1);
            end else begin
                n_off     = '0;
                n_ent     = r_ent + ENT_W'(1);
                n_running = r_running + len;
                if (r_ent == ENT_W'(ENTRY_COUNT - 1)) begin
                    n_done = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done    <= 1'b1;
            r_in_hdr  <= 1'b1;
            r_hpos    <= '0;
            r_off     <= '0;
            r_ent     <= '0;
            r_running <= '0;
            r_hdr_low <= '0;
        end else begin
            r_done    <= n_done;
            r_in_hdr  <= n_in_hdr;
            r_hpos    <= n_hpos;
            r_off     <= n_off;
            r_ent     <= n_ent;
            r_running <= n_running;
            r_hdr_low <= n_hdr_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_byte) begin
            r_ent_bytes[r_off] <= b;
        end
    end

endmodule

>>> hdl/rt11de_back.sv
// entry decoder: rad50 split in two stages, date unpacking, output register
module rt11de_back
    import rt11de_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_q_job,
    input  t_q_status i_q_status,
    output logic      o_q_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    typedef struct packed {
        logic [2:0][15:0] w;
        logic [2:0][10:0] q;
        logic [2:0][5:0]  top;
        t_out_word        base;
    } t_mid;

    logic      r_mid_valid;
    logic      r_out_valid;
    t_mid      r_mid;
    t_out_word r_out;
    logic      n_mid_valid;
    logic      n_out_valid;
    t_mid      n_mid;
    t_out_word n_out;
    logic      adv_out;
    logic      adv_mid;
    logic [15:0] date;

    assign adv_out     = !r_out_valid || i_out_ready;
    assign adv_mid     = !r_mid_valid || adv_out;
    assign o_q_pop     = !i_q_status.empty && adv_mid;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign date        = {i_q_job.raw[13], i_q_job.raw[12]};

    // first stage: quotients by 40 and 1600, plain fields
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_mid.w[k]   = {i_q_job.raw[2*k+3], i_q_job.raw[2*k+2]};
            n_mid.q[k]   = f_div40(n_mid.w[k]);
            n_mid.top[k] = f_div1600(n_mid.w[k]);
        end
        n_mid.base                 = '0;
        n_mid.base.status_low      = i_q_job.raw[0];
        n_mid.base.entry_kind      = i_q_job.raw[1];
        n_mid.base.start_block     = i_q_job.start_block;
        n_mid.base.length_blocks   = {i_q_job.raw[9], i_q_job.raw[8]};
        n_mid.base.job_number      = i_q_job.raw[10];
        n_mid.base.channel_number  = i_q_job.raw[11];
        n_mid.base.day_of_month    = date[9:5];
        n_mid.base.month_number    = date[13:10];
        n_mid.base.year_since_1900 = {2'b00, date[4:0]} + YEAR_BIAS;
    end

    // second stage: remainders and character lookup
    always_comb begin
        logic [15:0]      r16;
        logic [10:0]      r11;
        logic [2:0][23:0] text;
        logic [2:0]       bad;
        for (int k = 0; k < 3; k++) begin
            r16 = r_mid.w[k] - ({5'd0, r_mid.q[k]} << 5) - ({5'd0, r_mid.q[k]} << 3);
            r11 = r_mid.q[k] - ({5'd0, r_mid.top[k]} << 5) - ({5'd0, r_mid.top[k]} << 3);
            bad[k]  = (r_mid.top[k] >= RAD_BASE);
            text[k] = {f_rad_char(r_mid.top[k]), f_rad_char(r11[5:0]),
                       f_rad_char(r16[5:0])};
        end
        n_out              = r_mid.base;
        n_out.stem_ascii   = {text[0], text[1]};
        n_out.ext_ascii    = text[2];
        n_out.name_invalid = |bad;
    end

    assign n_mid_valid = adv_mid ? o_q_pop : r_mid_valid;
    assign n_out_valid = adv_out ? r_mid_valid : r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mid_valid <= n_mid_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_mid <= n_mid;
        end
        if (adv_out && r_mid_valid) begin
            r_out <= n_out;
        end
    end

endmodule

>>> verif/rt11_directory_entry_decoder_tb.sv
// self-checking testbench for the rt11 directory entry decoder
module rt11_directory_entry_decoder_tb;
    import rt11de_pkg::*;

    localparam int CLK_PERIOD = 4;
    localparam int unsigned NUM_ENTRIES = ENTRY_COUNT_DEF;
    localparam int unsigned RADIX = 40;
    localparam int unsigned SEG_BYTES = HDR_BYTES + ENT_BYTES * NUM_ENTRIES;
    // rad50 character set, digit 0 in the top byte
    localparam logic [8*40-1:0] RAD_SET = " ABCDEFGHIJKLMNOPQRSTUVWXYZ$.%0123456789";
    // status ff, end mark, largest valid word, smallest bad word, blank extension,
    // length ffff, job 0, channel ff, date with every field at its maximum
    localparam logic [8*14-1:0] EXTREME_ENTRY = 112'hFF08_FFF9_00FA_0000_FFFF_00FF_FFFF;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_word o_out_word;

    // segment tracking state
    logic [11:0] seg_pos;
    logic        seg_waiting;
    logic [15:0] next_block;
    logic [7:0]  begin_lo;
    logic [7:0]  entry_buf [ENT_BYTES-1];

    t_out_word pending_entries[$];
    int mismatch_count = 0;
    int unsigned bytes_sent = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;

    rt11_directory_entry_decoder #(
        .ENTRY_COUNT(NUM_ENTRIES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // {bad top digit, three ascii characters}
    function automatic logic [24:0] rad_triplet(input logic [15:0] w);
        int unsigned top, mid, low;
        logic [7:0] first;
        top = w / (RADIX * RADIX);
        mid = (w / RADIX) % RADIX;
        low = w % RADIX;
        first = (top >= RADIX) ? BAD_CHAR : RAD_SET[8*(RADIX-1-top) +: 8];
        return {top >= RADIX, first, RAD_SET[8*(RADIX-1-mid) +: 8],
                RAD_SET[8*(RADIX-1-low) +: 8]};
    endfunction

    task automatic track_segment_byte(input t_in_word w);
        t_out_word e;
        logic [11:0] p;
        int unsigned off;
        logic [15:0] len, date;
        logic [24:0] t1, t2, t3;
        if (w.segment_start) begin
            seg_pos = '0;
            seg_waiting = 1'b0;
        end
        if (!seg_waiting) begin
            p = seg_pos;
            seg_pos = p + 1'b1;
            if (p < HDR_BYTES) begin
                if (p == 8) begin
                    begin_lo = w.data_byte;
                end else if (p == 9) begin
                    next_block = {w.data_byte, begin_lo};
                end
            end else begin
                off = (p - HDR_BYTES) % ENT_BYTES;
                if (off < ENT_BYTES - 1) begin
                    entry_buf[off] = w.data_byte;
                end else begin
                    t1 = rad_triplet({entry_buf[3], entry_buf[2]});
                    t2 = rad_triplet({entry_buf[5], entry_buf[4]});
                    t3 = rad_triplet({entry_buf[7], entry_buf[6]});
                    len = {entry_buf[9], entry_buf[8]};
                    date = {w.data_byte, entry_buf[12]};
                    e.status_low      = entry_buf[0];
                    e.entry_kind      = entry_buf[1];
                    e.stem_ascii      = {t1[23:0], t2[23:0]};
                    e.ext_ascii       = t3[23:0];
                    e.name_invalid    = t1[24] | t2[24] | t3[24];
                    e.start_block     = next_block;
                    e.length_blocks   = len;
                    e.job_number      = entry_buf[10];
                    e.channel_number  = entry_buf[11];
                    e.day_of_month    = date[9:5];
                    e.month_number    = date[13:10];
                    e.year_since_1900 = {2'b00, date[4:0]} + YEAR_BIAS;
                    pending_entries.push_back(e);
                    next_block = next_block + len;
                    if (p + 1 >= SEG_BYTES) begin
                        seg_waiting = 1'b1;
                    end
                end
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] data, input logic start);
        t_in_word w;
        w.data_byte = data;
        w.segment_start = start;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        track_segment_byte(w);
        bytes_sent++;
    endtask

    task automatic send_header(input logic [15:0] begin_block);
        send_byte(8'($urandom_range(255)), 1'b1);
        repeat (7) send_byte(8'($urandom_range(255)), 1'b0);
        send_byte(begin_block[7:0], 1'b0);
        send_byte(begin_block[15:8], 1'b0);
    endtask

    // mostly valid rad50 words, with the edges and bad top digits now and then
    function automatic logic [15:0] rand_name_word();
        int unsigned r;
        r = $urandom_range(15);
        if (r == 0) begin
            return 16'($urandom_range(65535, 64000));
        end else if (r == 1) begin
            return $urandom_range(1) ? 16'd63999 : 16'd0;
        end
        return 16'($urandom_range(63999));
    endfunction

    // sends the first n_bytes of a random entry
    task automatic send_entry(input int unsigned n_bytes);
        logic [7:0] ent [ENT_BYTES];
        logic [15:0] stem1, stem2, ext, len, date;
        int unsigned r;
        stem1 = rand_name_word();
        stem2 = rand_name_word();
        ext = rand_name_word();
        r = $urandom_range(7);
        if (r < 2) begin
            len = 16'($urandom_range(20));
        end else if (r == 2) begin
            len = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        end else begin
            len = 16'($urandom_range(65535));
        end
        date = 16'($urandom_range(65535));
        ent[0] = 8'($urandom_range(255));
        r = $urandom_range(7);
        ent[1] = (r < 6) ? 8'(1 << (r % 4)) : 8'($urandom_range(255));
        {ent[3], ent[2]} = stem1;
        {ent[5], ent[4]} = stem2;
        {ent[7], ent[6]} = ext;
        {ent[9], ent[8]} = len;
        ent[10] = 8'($urandom_range(255));
        ent[11] = 8'($urandom_range(255));
        {ent[13], ent[12]} = date;
        for (int i = 0; i < n_bytes; i++) begin
            send_byte(ent[i], 1'b0);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_entries.size() != 0);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int unsigned n_bytes);
        int unsigned stop_at, pick;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(9);
            if (pick < 7) begin
                send_header(16'($urandom_range(65535)));
                repeat ($urandom_range(6)) send_entry(ENT_BYTES);
                // cut off inside an entry, the next start restarts
                if (pick == 6) begin
                    send_entry($urandom_range(ENT_BYTES - 1));
                end
            end else if (pick == 7) begin
                send_byte(8'($urandom_range(255)), 1'b1);
                repeat ($urandom_range(8)) send_byte(8'($urandom_range(255)), 1'b0);
            end else begin
                repeat ($urandom_range(20, 1)) begin
                    send_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
                end
            end
        end
        wait_drained();
    endtask

    task automatic test_bytes_before_start();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
    endtask

    task automatic test_restart_and_extremes();
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_header(16'hFFFF);
        for (int i = 0; i < ENT_BYTES; i++) begin
            send_byte(EXTREME_ENTRY[8*(ENT_BYTES-1-i) +: 8], 1'b0);
        end
        wait_drained();
    endtask

    task automatic test_receiver_holdoff();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 600;
        send_header(16'($urandom_range(65535)));
        repeat (NUM_ENTRIES) send_entry(ENT_BYTES);
        // past the last entry everything is dropped until a new start
        repeat (20) send_byte(8'($urandom_range(255)), 1'b0);
        wait_drained();
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left--;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [47:0] want, input logic [47:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("mismatch in %s: expected %0h, got %0h", name, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_entries.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("output word with no entry pending: %0h", o_out_word);
                end
            end else begin
                want = pending_entries.pop_front();
                check_field("status_low", want.status_low, o_out_word.status_low);
                check_field("entry_kind", want.entry_kind, o_out_word.entry_kind);
                check_field("stem_ascii", want.stem_ascii, o_out_word.stem_ascii);
                check_field("ext_ascii", want.ext_ascii, o_out_word.ext_ascii);
                check_field("name_invalid", want.name_invalid, o_out_word.name_invalid);
                check_field("start_block", want.start_block, o_out_word.start_block);
                check_field("length_blocks", want.length_blocks, o_out_word.length_blocks);
                check_field("job_number", want.job_number, o_out_word.job_number);
                check_field("channel_number", want.channel_number, o_out_word.channel_number);
                check_field("day_of_month", want.day_of_month, o_out_word.day_of_month);
                check_field("month_number", want.month_number, o_out_word.month_number);
                check_field("year_since_1900", want.year_since_1900,
                            o_out_word.year_since_1900);
            end
        end
    end

    initial begin
        seg_pos = '0;
        seg_waiting = 1'b1;
        next_block = '0;
        begin_lo = '0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_word <= '0;
        i_out_ready <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_bytes_before_start();
        test_restart_and_extremes();
        run_phase(0, 0, 140);
        run_phase(85, 0, 140);
        test_receiver_holdoff();
        run_phase(0, 85, 140);
        run_phase(6, 6, 140);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_entries.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #(CLK_PERIOD * 400000);
        $display("simulation failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/rt11de_pkg.sv
hdl/rt11de_fifo.sv
hdl/rt11de_front.sv
hdl/rt11de_back.sv
hdl/rt11_directory_entry_decoder.sv
verif/rt11_directory_entry_decoder_tb.sv
